>>> hw/rtl/nat_pkg.sv
// Shared types, constants and helpers for the nearest angle table lookup.
// No dependencies; imported by the top level and nat_scan.
package nat_pkg;

  // Table geometry
  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned IN_ANG_W = 11;
  localparam int unsigned ANG_W    = 9;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned SLOT_W   = ANG_W + ID_W;

  // Degrees in a full turn
  localparam int unsigned FULL_CIRCLE = 360;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  // One stored slot
  typedef struct packed {
    logic [ANG_W-1:0] angle;
    logic [ID_W-1:0]  ident;
  } slot_t;

  // Control from the sequencer to the scan datapath
  typedef struct packed {
    logic             clr;
    logic             proc;
    logic             lookup;
    logic             slot_vld;
    logic [IDX_W-1:0] idx;
    logic [ANG_W-1:0] query;
  } scan_ctrl_t;

  // Outcome of a table walk
  typedef struct packed {
    logic             same_found;
    logic [IDX_W-1:0] same_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             hit;
    logic [ANG_W-1:0] match_angle;
    logic [ID_W-1:0]  match_ident;
  } scan_res_t;

  // Reduce a signed 11-bit angle into 0..359 (true modulo)
  function automatic logic [ANG_W-1:0] reduce_angle(input logic [IN_ANG_W-1:0] raw);
    logic [IN_ANG_W:0] v;
    v = {raw[IN_ANG_W-1], raw} + (IN_ANG_W+1)'(3 * FULL_CIRCLE);
    if (v >= (IN_ANG_W+1)'(4 * FULL_CIRCLE)) v = v - (IN_ANG_W+1)'(4 * FULL_CIRCLE);
    if (v >= (IN_ANG_W+1)'(2 * FULL_CIRCLE)) v = v - (IN_ANG_W+1)'(2 * FULL_CIRCLE);
    if (v >= (IN_ANG_W+1)'(FULL_CIRCLE))     v = v - (IN_ANG_W+1)'(FULL_CIRCLE);
    return v[ANG_W-1:0];
  endfunction

  // Clockwise gap from 'from' up to 'to', both in 0..359
  function automatic logic [ANG_W-1:0] circ_gap(input logic [ANG_W-1:0] from,
                                                 input logic [ANG_W-1:0] to);
    logic [ANG_W:0] g;
    if (to >= from) begin
      g = {1'b0, to} - {1'b0, from};
    end else begin
      g = {1'b0, to} + (ANG_W+1)'(FULL_CIRCLE) - {1'b0, from};
    end
    return g[ANG_W-1:0];
  endfunction

endpackage

>>> hw/rtl/nearest_angle_table_lookup.sv
// Top level of the nearest angle table lookup: sequencer, slot valid bits,
// slot memory and output register. Depends on nat_pkg, nat_ram and nat_scan.

// A request clears the table, inserts an (angle, id) entry or looks up the
// stored entry nearest to a query angle on the circle; angles are reduced
// modulo 360 first, and every request returns exactly one result. Angles and
// ids live in a single-port-read slot memory that is walked one slot per
// cycle: an insert or a lookup reads every slot in turn before its result
// is built; a clear or an unused mode goes straight to the result.
// The next request is taken as soon as the previous result is in the output
// register, and a result waits there while the output is stalled. Slot valid
// bits are flip-flops cleared at reset, so no clearing pass is needed.
module nearest_angle_table_lookup
  import nat_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [IN_ANG_W-1:0] angle_i,
  input  logic [ID_W-1:0]     entry_id_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                hit_o,
  output logic [ANG_W-1:0]    matched_angle_o,
  output logic [ID_W-1:0]     matched_id_o,
  output logic                table_full_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic               rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [ANG_W-1:0]   ang_q, ang_d;
  logic [ID_W-1:0]    id_q, id_d;
  logic [TABLE_ENTRIES-1:0] slot_valid_q, slot_valid_d;

  logic               out_valid_q, out_valid_d;
  logic               hit_q, hit_d;
  logic [ANG_W-1:0]   m_ang_q, m_ang_d;
  logic [ID_W-1:0]    m_id_q, m_id_d;
  logic               full_q, full_d;

  logic               in_fire, resp_fire;
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr;
  slot_t              ram_wdata, ram_rdata;
  logic [SLOT_W-1:0]  ram_rdata_raw;
  scan_ctrl_t         scan_ctrl;
  scan_res_t          scan_res;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign resp_fire  = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  // Sequence accept, slot walk and result
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rd_pend_d = 1'b0;
    rd_idx_d  = rd_idx_q;
    mode_d    = mode_q;
    ang_d     = ang_q;
    id_d      = id_q;
    ram_re    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mode_d = mode_i;
          ang_d  = reduce_angle(angle_i);
          id_d   = entry_id_i;
          cnt_d  = '0;
          if (mode_i == MODE_INSERT || mode_i == MODE_LOOKUP) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        ram_re    = 1'b1;
        rd_pend_d = 1'b1;
        rd_idx_d  = cnt_q;
        if (cnt_q == LAST_IDX) begin
          state_d = ST_LAST;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_LAST: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (resp_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Drive the scan datapath
  always_comb begin
    scan_ctrl.clr      = in_fire;
    scan_ctrl.proc     = rd_pend_q;
    scan_ctrl.lookup   = (mode_q == MODE_LOOKUP);
    scan_ctrl.slot_vld = slot_valid_q[rd_idx_q];
    scan_ctrl.idx      = rd_idx_q;
    scan_ctrl.query    = ang_q;
  end

  // Write back an insert: replace a matching angle, else take the free slot
  assign ram_we    = resp_fire && (mode_q == MODE_INSERT) &&
                     (scan_res.same_found || scan_res.free_found);
  assign ram_waddr = scan_res.same_found ? scan_res.same_idx : scan_res.free_idx;
  assign ram_wdata = '{angle: ang_q, ident: id_q};
  assign ram_rdata = slot_t'(ram_rdata_raw);

  // Update slot valid bits
  always_comb begin
    slot_valid_d = slot_valid_q;
    if (resp_fire && mode_q == MODE_CLEAR) begin
      slot_valid_d = '0;
    end else if (ram_we && !scan_res.same_found) begin
      slot_valid_d[scan_res.free_idx] = 1'b1;
    end
  end

  // Build the result
  always_comb begin
    hit_d   = 1'b0;
    m_ang_d = '0;
    m_id_d  = '0;
    full_d  = 1'b0;
    case (mode_q)
      MODE_LOOKUP: begin
        hit_d = scan_res.hit;
        if (scan_res.hit) begin
          m_ang_d = scan_res.match_angle;
          m_id_d  = scan_res.match_ident;
        end
      end
      MODE_INSERT: begin
        full_d = !scan_res.same_found && !scan_res.free_found;
      end
      default: begin
        full_d = 1'b0;
      end
    endcase
  end

  assign out_valid_d = resp_fire || (out_valid_q && out_stall_i);

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_pend_q    <= 1'b0;
      slot_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_pend_q    <= rd_pend_d;
      slot_valid_q <= slot_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Hold request and result payload
  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    rd_idx_q <= rd_idx_d;
    mode_q   <= mode_d;
    ang_q    <= ang_d;
    id_q     <= id_d;
    if (resp_fire) begin
      hit_q   <= hit_d;
      m_ang_q <= m_ang_d;
      m_id_q  <= m_id_d;
      full_q  <= full_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign matched_angle_o = m_ang_q;
  assign matched_id_o    = m_id_q;
  assign table_full_o    = full_q;

  nat_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(cnt_q),
    .rdata_o(ram_rdata_raw)
  );

  nat_scan u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(scan_ctrl),
    .slot_i(ram_rdata),
    .res_o (scan_res)
  );

`ifndef SYNTH
  // Memory is written only when a result leaves
  a_write_at_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_RESP))
    else $error("slot write outside result state");

  // A completed clear leaves no valid slot
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resp_fire && mode_q == MODE_CLEAR) |=> (slot_valid_q == '0))
    else $error("clear left valid slots");

  // A pending hit implies a non-empty table
  a_hit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (slot_valid_q != '0))
    else $error("hit reported with empty table");

  // Hit and full never come together
  a_hit_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && table_full_o))
    else $error("hit and table_full both set");

  // Read data is folded only during the walk
  a_proc_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_SCAN || state_q == ST_LAST))
    else $error("read data consumed outside walk");
`endif

endmodule

>>> hw/rtl/nat_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module nat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> hw/rtl/nat_scan.sv
// Scan datapath: folds one slot per cycle into the match, free-slot and
// nearest-neighbor trackers. Depends on nat_pkg.
module nat_scan
  import nat_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  scan_ctrl_t ctrl_i,
  input  slot_t      slot_i,
  output scan_res_t  res_o
);

  logic             same_found_q, same_found_d;
  logic [IDX_W-1:0] same_idx_q, same_idx_d;
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic             found_q, found_d;
  logic [ANG_W-1:0] lo_gap_q, lo_gap_d, up_gap_q, up_gap_d;
  slot_t            lo_slot_q, lo_slot_d, up_slot_q, up_slot_d;
  logic [ANG_W-1:0] ccw_gap, cw_gap;

  assign ccw_gap = circ_gap(slot_i.angle, ctrl_i.query);
  assign cw_gap  = circ_gap(ctrl_i.query, slot_i.angle);

  // Fold the current slot into the trackers
  always_comb begin
    same_found_d = same_found_q;
    same_idx_d   = same_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    found_d      = found_q;
    lo_gap_d     = lo_gap_q;
    up_gap_d     = up_gap_q;
    lo_slot_d    = lo_slot_q;
    up_slot_d    = up_slot_q;
    if (ctrl_i.clr) begin
      same_found_d = 1'b0;
      free_found_d = 1'b0;
      found_d      = 1'b0;
    end else if (ctrl_i.proc) begin
      if (ctrl_i.slot_vld) begin
        if (!same_found_q && slot_i.angle == ctrl_i.query) begin
          same_found_d = 1'b1;
          same_idx_d   = ctrl_i.idx;
        end
        if (ctrl_i.lookup) begin
          found_d = 1'b1;
          if (!found_q || ccw_gap < lo_gap_q) begin
            lo_gap_d  = ccw_gap;
            lo_slot_d = slot_i;
          end
          if (!found_q || cw_gap < up_gap_q) begin
            up_gap_d  = cw_gap;
            up_slot_d = slot_i;
          end
        end
      end else if (!free_found_q) begin
        free_found_d = 1'b1;
        free_idx_d   = ctrl_i.idx;
      end
    end
  end

  // Hold tracker flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      same_found_q <= 1'b0;
      free_found_q <= 1'b0;
      found_q      <= 1'b0;
    end else begin
      same_found_q <= same_found_d;
      free_found_q <= free_found_d;
      found_q      <= found_d;
    end
  end

  // Hold tracker payload
  always_ff @(posedge clk_i) begin
    same_idx_q <= same_idx_d;
    free_idx_q <= free_idx_d;
    lo_gap_q   <= lo_gap_d;
    up_gap_q   <= up_gap_d;
    lo_slot_q  <= lo_slot_d;
    up_slot_q  <= up_slot_d;
  end

  // Pick the upper neighbor only when strictly closer
  always_comb begin
    res_o.same_found  = same_found_q;
    res_o.same_idx    = same_idx_q;
    res_o.free_found  = free_found_q;
    res_o.free_idx    = free_idx_q;
    res_o.hit         = found_q;
    res_o.match_angle = (up_gap_q < lo_gap_q) ? up_slot_q.angle : lo_slot_q.angle;
    res_o.match_ident = (up_gap_q < lo_gap_q) ? up_slot_q.ident : lo_slot_q.ident;
  end

endmodule

>>> tb/nat_result_checker.sv
// Checker for the nearest angle table lookup: watches both channels, keeps its own
// copy of the angle table, predicts each result and compares it. Depends on nat_pkg.
module nat_result_checker
  import nat_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [IN_ANG_W-1:0] angle_i,
  input  logic [ID_W-1:0]     entry_id_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                hit_i,
  input  logic [ANG_W-1:0]    matched_angle_i,
  input  logic [ID_W-1:0]     matched_id_i,
  input  logic                table_full_i,
  output int                  error_count_o,
  output int                  pending_o
);

  localparam int DEG_TURN    = int'(FULL_CIRCLE);

  typedef struct packed {
    logic             hit;
    logic [ANG_W-1:0] angle;
    logic [ID_W-1:0]  ident;
    logic             full;
  } lookup_result_t;

  // Shadow copy of the angle table
  logic             shadow_valid [TABLE_ENTRIES];
  logic [ANG_W-1:0] shadow_angle [TABLE_ENTRIES];
  logic [ID_W-1:0]  shadow_ident [TABLE_ENTRIES];

  lookup_result_t expected_q [$];
  lookup_result_t predicted;
  int             mismatches;
  int             pending_cnt;

  assign error_count_o = mismatches;
  assign pending_o     = pending_cnt;

  // Print one line for a mismatch and count it
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Reduce a signed angle into 0..359
  function automatic int fold_angle(input logic [IN_ANG_W-1:0] raw);
    int v;
    v = $signed(raw);
    v = v % DEG_TURN;
    if (v < 0) v += DEG_TURN;
    return v;
  endfunction

  // Update the shadow table for one request and work out its result
  task automatic apply_request(input logic [MODE_W-1:0] m, input logic [IN_ANG_W-1:0] raw,
                               input logic [ID_W-1:0] id, output lookup_result_t res);
    int q, same, free, lo, up, lo_gap, up_gap, g, h, a, pick;
    res  = '0;
    q    = fold_angle(raw);
    same = -1;
    free = -1;
    lo   = -1;
    up   = -1;
    lo_gap = 0;
    up_gap = 0;
    case (m)
      MODE_CLEAR: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) shadow_valid[i] = 1'b0;
      end
      MODE_INSERT: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (shadow_valid[i]) begin
            if (same < 0 && int'(shadow_angle[i]) == q) same = i;
          end else if (free < 0) begin
            free = i;
          end
        end
        if (same >= 0) begin
          shadow_ident[same] = id;
        end else if (free >= 0) begin
          shadow_valid[free] = 1'b1;
          shadow_angle[free] = ANG_W'(q);
          shadow_ident[free] = id;
        end else begin
          res.full = 1'b1;
        end
      end
      MODE_LOOKUP: begin
        // Track the nearest entry at or below the query and the nearest above it
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (shadow_valid[i]) begin
            a = int'(shadow_angle[i]);
            g = (q - a + DEG_TURN) % DEG_TURN;
            h = (a - q + DEG_TURN) % DEG_TURN;
            if (lo < 0 || g < lo_gap) begin
              lo     = i;
              lo_gap = g;
            end
            if (up < 0 || h < up_gap) begin
              up     = i;
              up_gap = h;
            end
          end
        end
        if (lo >= 0) begin
          pick      = (up_gap < lo_gap) ? up : lo;
          res.hit   = 1'b1;
          res.angle = shadow_angle[pick];
          res.ident = shadow_ident[pick];
        end
      end
      default: ;
    endcase
  endtask

  // Compare one accepted result with the oldest prediction
  task automatic check_result();
    lookup_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result with no request outstanding");
      return;
    end
    want = expected_q.pop_front();
    if (hit_i !== want.hit)
      report_mismatch($sformatf("hit %0b, expected %0b", hit_i, want.hit));
    if (matched_angle_i !== want.angle)
      report_mismatch($sformatf("matched_angle %0d, expected %0d", matched_angle_i, want.angle));
    if (matched_id_i !== want.ident)
      report_mismatch($sformatf("matched_id 0x%04h, expected 0x%04h", matched_id_i, want.ident));
    if (table_full_i !== want.full)
      report_mismatch($sformatf("table_full %0b, expected %0b", table_full_i, want.full));
  endtask

  // Retire results before taking new requests of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) shadow_valid[i] = 1'b0;
      expected_q.delete();
      mismatches  = 0;
      pending_cnt = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) begin
        apply_request(mode_i, angle_i, entry_id_i, predicted);
        expected_q.push_back(predicted);
      end
      pending_cnt = expected_q.size();
    end
  end

endmodule

>>> tb/nearest_angle_table_lookup_tb.sv
// Top of the nearest angle table lookup testbench: clock, reset, request stimulus,
// output stall pattern and verdict. Depends on nat_pkg, the block and nat_result_checker.
module nearest_angle_table_lookup_tb
  import nat_pkg::*;
();

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 900;
  localparam int LONG_HOLD       = 300;
  localparam int DRAIN_CYCLES    = 40;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [MODE_W-1:0]   mode;
  logic [IN_ANG_W-1:0] angle;
  logic [ID_W-1:0]     entry_id;
  logic                out_valid;
  logic                out_stall;
  logic                hit;
  logic [ANG_W-1:0]    matched_angle;
  logic [ID_W-1:0]     matched_id;
  logic                table_full;
  int                  error_count;
  int                  pending;

  // Sender burst state and receiver hold-off handshake
  int burst_left;
  bit no_idle;
  bit hold_go;
  bit hold_done;

  always #2 clk = ~clk;

  nearest_angle_table_lookup dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .mode_i          (mode),
    .angle_i         (angle),
    .entry_id_i      (entry_id),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .hit_o           (hit),
    .matched_angle_o (matched_angle),
    .matched_id_o    (matched_id),
    .table_full_o    (table_full)
  );

  nat_result_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .mode_i          (mode),
    .angle_i         (angle),
    .entry_id_i      (entry_id),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .hit_i           (hit),
    .matched_angle_i (matched_angle),
    .matched_id_i    (matched_id),
    .table_full_i    (table_full),
    .error_count_o   (error_count),
    .pending_o       (pending)
  );

  // Idle cycles before the next request: bursts of random length, random gaps
  function automatic int next_gap();
    if (no_idle) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(1, 24);
    return $urandom_range(1, 8);
  endfunction

  // Query or insert angle: coarse grid for repeats, values from -360 to 719, or any 11-bit value
  function automatic logic [IN_ANG_W-1:0] pick_angle();
    int v;
    case ($urandom_range(0, 2))
      0:       v = 15 * $urandom_range(0, 23);
      1:       v = $urandom_range(0, 1079) - 360;
      default: v = $urandom();
    endcase
    return IN_ANG_W'(v);
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(input logic [MODE_W-1:0] m, input int a, input int id);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    angle    <= IN_ANG_W'(a);
    entry_id <= ID_W'(id);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop offering until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Request stimulus and verdict
  initial begin
    int sel;
    int counted;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    mode       = MODE_CLEAR;
    angle      = '0;
    entry_id   = '0;
    burst_left = 0;
    no_idle    = 1'b0;
    hold_go    = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, unused mode, angle extremes, replace
    send_request(MODE_LOOKUP, 0, 16'h0);
    send_request(MODE_UNUSED, -1024, 16'hFFFF);
    send_request(MODE_INSERT, -1024, 16'hFFFF);
    send_request(MODE_INSERT, 1023, 16'h0000);
    send_request(MODE_INSERT, -360, 16'h0001);
    send_request(MODE_INSERT, 719, 16'h0002);
    send_request(MODE_INSERT, 416, 16'h1234);
    // Directed: exact hit, strictly nearer upper neighbor, ties go counter-clockwise
    send_request(MODE_LOOKUP, 0, 16'h0);
    send_request(MODE_LOOKUP, 180, 16'h0);
    send_request(MODE_LOOKUP, 28, 16'h0);
    send_request(MODE_LOOKUP, -29, 16'h0);
    // Directed: fill the table, overflow, replace while full, clear
    for (int k = 0; k < 12; k++) send_request(MODE_INSERT, 100 + 17 * k, 16'hA000 + k);
    send_request(MODE_INSERT, 200, 16'hBEEF);
    send_request(MODE_INSERT, 303, 16'h5A5A);
    send_request(MODE_CLEAR, 719, 16'hFFFF);
    send_request(MODE_LOOKUP, 5, 16'h0);

    // Random: mostly inserts and lookups, some clears, a little unused-mode noise
    counted = 0;
    while (counted < RANDOM_REQUESTS) begin
      no_idle = (counted >= 100 && counted < 200) || (counted >= 300 && counted < 360);
      if (counted == 300) hold_go = 1'b1;
      if (counted == 600) wait_drained();
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        send_request(MODE_CLEAR, pick_angle(), $urandom_range(0, 65535));
        counted++;
      end else if (sel < 6) begin
        send_request(MODE_UNUSED, pick_angle(), $urandom_range(0, 65535));
      end else if (sel < 52) begin
        send_request(MODE_INSERT, pick_angle(), $urandom_range(0, 65535));
        counted++;
      end else begin
        send_request(MODE_LOOKUP, pick_angle(), $urandom_range(0, 65535));
        counted++;
      end
    end

    // Drain and let the block settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Output stall pattern: phases of no stall, light, heavy and periodic stalls
  initial begin
    int pattern;
    int phase_left;
    int tick;
    out_stall  = 1'b0;
    hold_done  = 1'b0;
    pattern    = 0;
    phase_left = 0;
    tick       = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        // Hold off long enough for the block to back up onto its input
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (phase_left == 0) begin
          pattern    = $urandom_range(0, 3);
          phase_left = $urandom_range(20, 120);
        end
        phase_left--;
        tick++;
        case (pattern)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((tick % 8) < 3);
        endcase
      end
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
